FILE: design/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and codes for the banked priority queue block: the stored
// entry layout, the result status codes and the operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpq_pkg;

   localparam int FieldWidth = 16;

   typedef struct packed {
      logic [FieldWidth-1:0] client;
      logic [FieldWidth-1:0] key;
   } entry_type;

   typedef enum logic [1:0] {
      STATUS_ENTERED = 2'd0,
      STATUS_SERVED  = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      OP_ENTER = 1'b0,
      OP_SERVE = 1'b1
   } op_type;

endpackage

`default_nettype wire

FILE: design/bpq_cell.sv
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted row. Decides whether the slot keeps its entry,
// takes the new entry, takes its left neighbour's entry (insert) or its
// right neighbour's entry (serve). Passes its key compare to the right.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_cell
   import bpq_pkg::*;
(
   input  wire  logic      op_serve,
   input  wire  entry_type new_entry,
   input  wire  logic      slot_valid,
   input  wire  entry_type own_entry,
   input  wire  entry_type left_entry,
   input  wire  entry_type right_entry,
   input  wire  logic      left_ge,
   output logic            own_ge,
   output entry_type       next_entry
);

   assign own_ge = slot_valid && (own_entry.key >= new_entry.key);

   always_comb begin
      priority if (op_serve) begin
         next_entry = right_entry;
      end else if (own_ge) begin
         next_entry = own_entry;
      end else if (left_ge) begin
         next_entry = new_entry;
      end else begin
         next_entry = left_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/banked_priority_queues_core.sv
// ----------------------------------------------------------------------------
// banked_priority_queues_core
// Bank of priority queues held as rows of a row-wide memory, highest key
// first. A row of cells inserts or removes an item in one pass.
// ----------------------------------------------------------------------------
// an accepted item is registered (row read into row_rd_ff, busy_ff set), then its result into rsp_valid_ff
// a new item is taken only while busy is low (row read, then cell pass and write-back)
// busy is high for the one cycle between accept and the result strobe
// reset clears all queue counts at once; row contents need no clearing
// results cannot be held off and appear for exactly one cycle
`default_nettype none

module banked_priority_queues_core
   import bpq_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        start,
   output logic              busy,
   input  wire  logic        req_operation,
   input  wire  logic [2:0]  req_queue_index,
   input  wire  logic [15:0] req_client_id,
   input  wire  logic [15:0] req_age_key,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [15:0]       rsp_served_client,
   output logic [15:0]       rsp_served_key
);

   localparam int QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);

   typedef entry_type [QUEUE_DEPTH-1:0] row_type;

   row_type        row_mem [NUM_QUEUES];
   logic [CW-1:0]  count_ff [NUM_QUEUES];

   logic           busy_ff;
   logic           serve_ff;
   logic           q_ok_ff;
   logic [QAW-1:0] q_addr_ff;
   entry_type      new_entry_ff;
   logic [CW-1:0]  cnt_rd_ff;
   row_type        row_rd_ff;
   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic [15:0]    rsp_client_ff;
   logic [15:0]    rsp_key_ff;

   logic           accept;
   logic [6:0]     q_ext;
   logic           q_ok;
   logic [QAW-1:0] q_addr;
   logic           is_full;
   logic           is_empty;
   logic           do_write;
   logic [CW-1:0]  count_in;
   status_type     rsp_status_in;
   logic [15:0]    rsp_client_in;
   logic [15:0]    rsp_key_in;
   row_type        row_in;
   logic           cell_ge [QUEUE_DEPTH];

   assign accept = start && !busy_ff;
   assign q_ext  = {4'b0000, req_queue_index};
   assign q_ok   = q_ext < 7'(NUM_QUEUES);
   assign q_addr = q_ext[QAW-1:0];

   // row of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_g;
      if (i == 0) begin : g_first
         assign left_e = row_rd_ff[0];
         assign left_g = 1'b1;
      end else begin : g_mid
         assign left_e = row_rd_ff[i-1];
         assign left_g = cell_ge[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = row_rd_ff[i];
      end else begin : g_inner
         assign right_e = row_rd_ff[i+1];
      end
      bpq_cell u_cell (
         .op_serve    (serve_ff),
         .new_entry   (new_entry_ff),
         .slot_valid  (cnt_rd_ff > CW'(i)),
         .own_entry   (row_rd_ff[i]),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_ge     (left_g),
         .own_ge      (cell_ge[i]),
         .next_entry  (row_in[i])
      );
   end

   always_comb begin
      is_full       = !q_ok_ff || (cnt_rd_ff == CW'(QUEUE_DEPTH));
      is_empty      = !q_ok_ff || (cnt_rd_ff == '0);
      do_write      = 1'b0;
      count_in      = cnt_rd_ff;
      rsp_status_in = STATUS_ENTERED;
      rsp_client_in = '0;
      rsp_key_in    = '0;
      priority if (serve_ff) begin
         if (is_empty) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            do_write      = busy_ff;
            count_in      = cnt_rd_ff - CW'(1);
            rsp_status_in = STATUS_SERVED;
            rsp_client_in = row_rd_ff[0].client;
            rsp_key_in    = row_rd_ff[0].key;
         end
      end else begin
         if (is_full) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            do_write      = busy_ff;
            count_in      = cnt_rd_ff + CW'(1);
            rsp_status_in = STATUS_ENTERED;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
         if (do_write) begin
            count_ff[q_addr_ff] <= count_in;
         end
      end
   end

   // payload and row memory
   always_ff @(posedge clock) begin
      if (accept) begin
         serve_ff     <= (req_operation == OP_SERVE);
         q_ok_ff      <= q_ok;
         q_addr_ff    <= q_addr;
         new_entry_ff <= '{client: req_client_id, key: req_age_key};
         cnt_rd_ff    <= q_ok ? count_ff[q_addr] : '0;
         if (q_ok) begin
            row_rd_ff <= row_mem[q_addr];
         end
      end
      if (do_write) begin
         row_mem[q_addr_ff] <= row_in;
      end
      if (busy_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_client_ff <= rsp_client_in;
         rsp_key_ff    <= rsp_key_in;
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_served_client = rsp_client_ff;
   assign rsp_served_key    = rsp_key_ff;

endmodule

`default_nettype wire

FILE: design/bpq_checker.sv
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks of the banked priority queue block: item timing and
// result field rules, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_checker
   import bpq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_served_client,
   input wire logic [15:0] rsp_served_key
);

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_busy_result : assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("no result one cycle after busy");

   a_result_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in flight");

   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_SERVED)) |->
         ((rsp_served_client == '0) && (rsp_served_key == '0)))
      else $error("served fields not zero on non-served status");

   a_reset_idle : assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("not idle after reset");

endmodule

bind banked_priority_queues_core bpq_checker u_bpq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_served_client (rsp_served_client),
   .rsp_served_key    (rsp_served_key)
);

`default_nettype wire
